FILE: rtl/lc3eu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lc3eu_pkg;

  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned FLAGS_W    = 3;

  localparam logic [WORD_W-1:0]    PC_RESET    = 16'h3000;
  localparam logic [FLAGS_W-1:0]   FLAGS_RESET = 3'b010;
  localparam logic [REG_IDX_W-1:0] LINK_REG    = 3'd7;

  localparam logic [FLAGS_W-1:0] FLAG_N = 3'b100;
  localparam logic [FLAGS_W-1:0] FLAG_Z = 3'b010;
  localparam logic [FLAGS_W-1:0] FLAG_P = 3'b001;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_AND = 3'd1,
    OP_NOT = 3'd2,
    OP_BR  = 3'd3,
    OP_JMP = 3'd4,
    OP_JSR = 3'd5
  } opcode_t;

  function automatic logic [FLAGS_W-1:0] flags_of(input logic [WORD_W-1:0] v);
    logic [FLAGS_W-1:0] f;
    if (v[WORD_W-1]) begin
      f = FLAG_N;
    end else if (v == '0) begin
      f = FLAG_Z;
    end else begin
      f = FLAG_P;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lc3eu_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lc3eu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-before-write: a read at the write address returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lc3_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------------------
// in       | in_valid / in_ready   | opcode, instruction, offset
// out      | out_valid / out_ready | wrote_register, written_index, written_value,
//          |                       | next_pc, flags_out
//
// One item per cycle while out_ready is high; out_valid is registered after execute.
// The register file sits in two synchronous RAM copies (one per source operand),
// read at acceptance; the executing item's write is forwarded to the next item.
// Reset clears the valid bits of the register file, PC to 0x3000 and flags to Z.
// A stalled output holds the execute stage; input stalls only when both are full.

module lc3_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [15:0] instruction,
  input  wire logic [15:0] offset,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        wrote_register,
  output      logic [2:0]  written_index,
  output      logic [15:0] written_value,
  output      logic [15:0] next_pc,
  output      logic [2:0]  flags_out
);

  localparam int unsigned IW = lc3eu_pkg::REG_IDX_W;
  localparam int unsigned WW = lc3eu_pkg::WORD_W;
  localparam int unsigned FW = lc3eu_pkg::FLAGS_W;

  // execute stage
  logic                  s1_valid;
  lc3eu_pkg::opcode_t    s1_op;
  logic [WW-1:0]         s1_ins;
  logic [WW-1:0]         s1_off;

  // architectural state outside the RAM
  logic [WW-1:0]         pc;
  logic [FW-1:0]         flags;
  logic [lc3eu_pkg::NUM_REGS-1:0] reg_valid;

  // last register write, for forwarding into the next item
  logic                  lw_valid;
  logic [IW-1:0]         lw_idx;
  logic [WW-1:0]         lw_val;

  logic                  accept;
  logic                  advance;
  logic [WW-1:0]         rd_a;
  logic [WW-1:0]         rd_b;
  logic [IW-1:0]         sr1;
  logic [IW-1:0]         sr2;
  logic [WW-1:0]         op_a;
  logic [WW-1:0]         op_b;
  logic [WW-1:0]         pc_inc;
  logic [WW-1:0]         pc_next;
  logic [FW-1:0]         flags_next;
  logic                  wr_en;
  logic [IW-1:0]         wr_idx;
  logic [WW-1:0]         wr_val;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  assign sr1 = s1_ins[8:6];
  assign sr2 = s1_ins[2:0];

  lc3eu_ram #(.WIDTH(WW), .DEPTH(lc3eu_pkg::NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (advance && wr_en),
    .waddr (wr_idx),
    .wdata (wr_val),
    .re    (accept),
    .raddr (instruction[8:6]),
    .rdata (rd_a)
  );

  lc3eu_ram #(.WIDTH(WW), .DEPTH(lc3eu_pkg::NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (advance && wr_en),
    .waddr (wr_idx),
    .wdata (wr_val),
    .re    (accept),
    .raddr (instruction[2:0]),
    .rdata (rd_b)
  );

  // Forward the previous item's write; entries never written read as zero.
  always_comb begin
    if (lw_valid && (lw_idx == sr1)) begin
      op_a = lw_val;
    end else if (reg_valid[sr1]) begin
      op_a = rd_a;
    end else begin
      op_a = '0;
    end
    if (s1_ins[5]) begin
      op_b = s1_off;
    end else if (lw_valid && (lw_idx == sr2)) begin
      op_b = lw_val;
    end else if (reg_valid[sr2]) begin
      op_b = rd_b;
    end else begin
      op_b = '0;
    end
  end

  assign pc_inc = pc + WW'(1);

  always_comb begin
    pc_next    = pc_inc;
    flags_next = flags;
    wr_en      = 1'b0;
    wr_idx     = '0;
    wr_val     = '0;
    case (s1_op)
      lc3eu_pkg::OP_ADD: begin
        wr_en  = 1'b1;
        wr_idx = s1_ins[11:9];
        wr_val = op_a + op_b;
      end
      lc3eu_pkg::OP_AND: begin
        wr_en  = 1'b1;
        wr_idx = s1_ins[11:9];
        wr_val = op_a & op_b;
      end
      lc3eu_pkg::OP_NOT: begin
        wr_en  = 1'b1;
        wr_idx = s1_ins[11:9];
        wr_val = ~op_a;
      end
      lc3eu_pkg::OP_BR: begin
        if ((s1_ins[11:9] & flags) != '0) begin
          pc_next = pc_inc + s1_off;
        end
      end
      lc3eu_pkg::OP_JMP: begin
        pc_next = op_a;
      end
      lc3eu_pkg::OP_JSR: begin
        wr_en  = 1'b1;
        wr_idx = lc3eu_pkg::LINK_REG;
        wr_val = pc_inc;
        pc_next = s1_ins[11] ? (pc_inc + s1_off) : op_a;
      end
      default: begin
      end
    endcase
    if (wr_en && (s1_op != lc3eu_pkg::OP_JSR)) begin
      flags_next = lc3eu_pkg::flags_of(wr_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      lw_valid  <= 1'b0;
      reg_valid <= '0;
      pc        <= lc3eu_pkg::PC_RESET;
      flags     <= lc3eu_pkg::FLAGS_RESET;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        pc        <= pc_next;
        flags     <= flags_next;
        lw_valid  <= wr_en;
        if (wr_en) begin
          reg_valid[wr_idx] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= lc3eu_pkg::opcode_t'(opcode);
      s1_ins <= instruction;
      s1_off <= offset;
    end
    if (advance) begin
      lw_idx         <= wr_idx;
      lw_val         <= wr_val;
      wrote_register <= wr_en;
      written_index  <= wr_idx;
      written_value  <= wr_val;
      next_pc        <= pc_next;
      flags_out      <= flags_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lc3eu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lc3eu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        wrote_register,
  input wire logic [2:0]  written_index,
  input wire logic [15:0] written_value,
  input wire logic [15:0] next_pc,
  input wire logic [2:0]  flags_out
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(written_value) && $stable(next_pc)
      && $stable(flags_out) && $stable(written_index) && $stable(wrote_register))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(flags_out))
    else $error("flags not one-hot");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !wrote_register |-> written_index == 3'd0 && written_value == 16'd0)
    else $error("write fields set without a register write");

  // with the output free, the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_ready |=> out_valid)
    else $error("input stalled with empty output");

endmodule

bind lc3_execute_unit lc3eu_checker u_lc3eu_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .wrote_register (wrote_register),
  .written_index  (written_index),
  .written_value  (written_value),
  .next_pc        (next_pc),
  .flags_out      (flags_out)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic        wr;
  logic [2:0]  idx;
  logic [15:0] val;
  logic [15:0] pc;
  logic [2:0]  cc;
} retire_t;

class RetireScoreboard;
  logic [15:0] gpr [lc3eu_pkg::NUM_REGS];
  logic [15:0] pc;
  logic [2:0]  cc;
  retire_t     pending_retires[$];
  int          mismatches;
  int          retired;
  int          issued;
  int          taken_branches;
  int          reg_writes;
  int          op_count [8];

  function new();
    for (int i = 0; i < lc3eu_pkg::NUM_REGS; i++) begin
      gpr[i] = '0;
    end
    pc = lc3eu_pkg::PC_RESET;
    cc = lc3eu_pkg::FLAGS_RESET;
    mismatches = 0;
    retired = 0;
    issued = 0;
    taken_branches = 0;
    reg_writes = 0;
    for (int i = 0; i < 8; i++) begin
      op_count[i] = 0;
    end
  endfunction

  function logic [2:0] cc_from_value(logic [15:0] v);
    if (v[15]) begin
      return lc3eu_pkg::FLAG_N;
    end
    if (v == 16'h0000) begin
      return lc3eu_pkg::FLAG_Z;
    end
    return lc3eu_pkg::FLAG_P;
  endfunction

  // Advance the architectural copy by one instruction and queue its retire.
  function void note_issue(logic [2:0] op, logic [15:0] ins, logic [15:0] off);
    retire_t     r;
    logic [2:0]  dr;
    logic [2:0]  sr1;
    logic [2:0]  sr2;
    logic [15:0] b;
    dr  = ins[11:9];
    sr1 = ins[8:6];
    sr2 = ins[2:0];
    r   = '0;
    pc  = pc + 16'd1;
    case (op)
      lc3eu_pkg::OP_ADD: begin
        b = ins[5] ? off : gpr[sr2];
        r.val = gpr[sr1] + b;
        r.wr = 1'b1;
        r.idx = dr;
      end
      lc3eu_pkg::OP_AND: begin
        b = ins[5] ? off : gpr[sr2];
        r.val = gpr[sr1] & b;
        r.wr = 1'b1;
        r.idx = dr;
      end
      lc3eu_pkg::OP_NOT: begin
        r.val = ~gpr[sr1];
        r.wr = 1'b1;
        r.idx = dr;
      end
      lc3eu_pkg::OP_BR: begin
        if ((ins[11:9] & cc) != 3'b000) begin
          pc = pc + off;
          taken_branches++;
        end
      end
      lc3eu_pkg::OP_JMP: begin
        pc = gpr[sr1];
      end
      lc3eu_pkg::OP_JSR: begin
        // read the base before the link lands in R7
        b = gpr[sr1];
        r.val = pc;
        r.wr = 1'b1;
        r.idx = lc3eu_pkg::LINK_REG;
        pc = ins[11] ? pc + off : b;
      end
      default: begin
      end
    endcase
    if (r.wr) begin
      gpr[r.idx] = r.val;
      reg_writes++;
      if (op != lc3eu_pkg::OP_JSR) begin
        cc = cc_from_value(r.val);
      end
    end
    r.pc = pc;
    r.cc = cc;
    pending_retires.push_back(r);
    op_count[op]++;
    issued++;
  endfunction

  function void check_retire(retire_t got);
    retire_t want;
    if (pending_retires.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] result with no item pending: wr=%0d idx=%0d val=%h pc=%h cc=%b",
                 $realtime, got.wr, got.idx, got.val, got.pc, got.cc);
      end
      return;
    end
    want = pending_retires.pop_front();
    retired++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] result %0d mismatch", $realtime, retired);
        $display("  expected wr=%0d idx=%0d val=%h pc=%h cc=%b",
                 want.wr, want.idx, want.val, want.pc, want.cc);
        $display("  actual   wr=%0d idx=%0d val=%h pc=%h cc=%b",
                 got.wr, got.idx, got.val, got.pc, got.cc);
      end
    end
  endfunction

  function int pending();
    return pending_retires.size();
  endfunction
endclass

module tb;

  localparam logic [2:0] OPC_SPARE_LO = 3'd6;
  localparam logic [2:0] OPC_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int CYCLE_LIMIT   = 900000;
  localparam int SQUEEZE_AT    = 400;
  localparam int SQUEEZE_LEN   = 300;
  localparam int DRAIN_CYCLES  = 10;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  opcode;
  logic [15:0] instruction;
  logic [15:0] offset;
  logic        out_valid;
  logic        out_ready;
  logic        wrote_register;
  logic [2:0]  written_index;
  logic [15:0] written_value;
  logic [15:0] next_pc;
  logic [2:0]  flags_out;

  RetireScoreboard sb;
  int              cycle_count = 0;

  lc3_execute_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .instruction   (instruction),
    .offset        (offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .wrote_register(wrote_register),
    .written_index (written_index),
    .written_value (written_value),
    .next_pc       (next_pc),
    .flags_out     (flags_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Mostly zero, sometimes a few cycles, rarely a long pause.
  function int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function logic [15:0] word(logic [2:0] f11_9, logic [2:0] f8_6, logic b5, logic [4:0] low5);
    logic [3:0] hi;
    hi = 4'($urandom_range(0, 15));
    return {hi, f11_9, f8_6, b5, low5};
  endfunction

  function logic [15:0] rand_offset();
    int r;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    v = 16'($urandom_range(0, 65535));
    if (r < 40) begin
      return {{11{v[4]}}, v[4:0]};
    end
    if (r < 60) begin
      return {{7{v[8]}}, v[8:0]};
    end
    if (r < 90) begin
      return v;
    end
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function logic [2:0] rand_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return lc3eu_pkg::OP_ADD;
    if (r < 40) return lc3eu_pkg::OP_AND;
    if (r < 50) return lc3eu_pkg::OP_NOT;
    if (r < 70) return lc3eu_pkg::OP_BR;
    if (r < 80) return lc3eu_pkg::OP_JMP;
    return lc3eu_pkg::OP_JSR;
  endfunction

  // Offer one item after an optional gap and hold it until accepted.
  task automatic issue(logic [2:0] op, logic [15:0] ins, logic [15:0] off, bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    instruction <= ins;
    offset      <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_issue(op, ins, off);
  endtask

  initial begin : result_sink
    int  hold;
    bit  squeezed;
    retire_t got;
    hold = 0;
    squeezed = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.wr  = wrote_register;
        got.idx = written_index;
        got.val = written_value;
        got.pc  = next_pc;
        got.cc  = flags_out;
        sb.check_retire(got);
      end
      // hold off once for a long stretch so the pipe fills and backs up
      if (!squeezed && sb.retired >= SQUEEZE_AT) begin
        squeezed = 1;
        hold = SQUEEZE_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (sb.retired < 1000 || sb.retired >= 1200) begin
          hold = pick_idle();
        end
      end
    end
  end

  initial begin : stimulus
    bit calm;
    sb = new();
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    opcode      <= '0;
    instruction <= '0;
    offset      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(lc3eu_pkg::OP_ADD, word(3'd1, 3'd0, 1'b1, 5'd0),  16'h7FFF, 0);
    issue(lc3eu_pkg::OP_ADD, word(3'd1, 3'd1, 1'b1, 5'd1),  16'h0001, 0); // overflow
    issue(lc3eu_pkg::OP_ADD, word(3'd2, 3'd0, 1'b1, 5'h1F), 16'hFFFF, 0);
    issue(lc3eu_pkg::OP_ADD, word(3'd3, 3'd1, 1'b0, 5'd2),  16'h1234, 0);
    issue(lc3eu_pkg::OP_AND, word(3'd4, 3'd2, 1'b1, 5'd0),  16'h0000, 0);
    issue(lc3eu_pkg::OP_AND, word(3'd5, 3'd2, 1'b0, 5'd1),  16'hA5A5, 0);
    issue(lc3eu_pkg::OP_BR,  word(3'b010, 3'd0, 1'b0, 5'd0), 16'h8000, 0);
    issue(lc3eu_pkg::OP_BR,  word(3'b000, 3'd7, 1'b1, 5'h1F), 16'h7FFF, 0); // empty mask
    issue(lc3eu_pkg::OP_NOT, word(3'd6, 3'd0, 1'b1, 5'h1F), 16'hFFFF, 0);
    issue(lc3eu_pkg::OP_BR,  word(3'b100, 3'd0, 1'b0, 5'd0), 16'h7FFF, 0);
    issue(lc3eu_pkg::OP_BR,  word(3'b001, 3'd0, 1'b0, 5'd0), 16'h0001, 0);
    issue(lc3eu_pkg::OP_NOT, word(3'd0, 3'd6, 1'b0, 5'd0),  16'h0000, 0);
    issue(lc3eu_pkg::OP_BR,  word(3'b111, 3'd0, 1'b0, 5'd0), 16'hFFFF, 0);
    issue(lc3eu_pkg::OP_JSR, word(3'b100, 3'd0, 1'b0, 5'd0), 16'h0010, 0);
    issue(lc3eu_pkg::OP_JMP, word(3'd0, 3'd7, 1'b0, 5'd0),  16'h0000, 0); // return via R7
    issue(lc3eu_pkg::OP_JSR, word(3'b011, 3'd7, 1'b0, 5'd0), 16'h0000, 0); // base is R7
    issue(lc3eu_pkg::OP_JSR, word(3'b111, 3'd0, 1'b1, 5'h1F), 16'hFFFF, 0);
    issue(lc3eu_pkg::OP_JMP, word(3'd0, 3'd1, 1'b0, 5'd0),  16'h0000, 0);
    issue(OPC_SPARE_LO, 16'hFFFF, 16'hFFFF, 0);
    issue(OPC_SPARE_HI, 16'h0000, 16'h0000, 0);
    issue(lc3eu_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 0);
    issue(lc3eu_pkg::OP_ADD, 16'h0000, 16'h0000, 0);
    issue(lc3eu_pkg::OP_AND, 16'hFFFF, 16'hFFFF, 0);
    issue(lc3eu_pkg::OP_NOT, 16'hFFFF, 16'h0000, 0);
    issue(lc3eu_pkg::OP_JSR, word(3'b000, 3'd3, 1'b0, 5'd0), 16'h0000, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // keep offering back to back around the receiver hold-off
      calm = (i >= 370 && i < 800);
      issue(rand_opcode(), 16'($urandom_range(0, 65535)), rand_offset(), calm);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items, %0d results checked: ADD %0d, AND %0d, NOT %0d,",
             sb.issued, sb.retired, sb.op_count[lc3eu_pkg::OP_ADD],
             sb.op_count[lc3eu_pkg::OP_AND], sb.op_count[lc3eu_pkg::OP_NOT]);
    $display("  BR %0d, JMP %0d, JSR %0d", sb.op_count[lc3eu_pkg::OP_BR],
             sb.op_count[lc3eu_pkg::OP_JMP], sb.op_count[lc3eu_pkg::OP_JSR]);
    $display("Branches taken %0d, register writes %0d, spare opcodes %0d, mismatches %0d",
             sb.taken_branches, sb.reg_writes,
             sb.op_count[OPC_SPARE_LO] + sb.op_count[OPC_SPARE_HI], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
